### hw/rtl/spead_header_item_parser_unit_macros.svh
// Assertion macros for the SPEAD header item parser.
// Included by the top level; expects clk and rst in the including scope.
`ifndef SPEAD_HEADER_ITEM_PARSER_UNIT_MACROS_SVH
`define SPEAD_HEADER_ITEM_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shp assertion failed");

// Next-cycle implication, disabled during reset
`define SHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shp assertion failed");

`endif

### hw/rtl/shp_pkg.sv
// Shared types and constants for the SPEAD header item parser.
// No dependencies.
package shp_pkg;

  // Header checks
  localparam logic [7:0] MAGIC   = 8'h53;
  localparam logic [7:0] VERSION = 8'h04;

  // Item ids of interest
  localparam logic [63:0] ID_HEAP_CNT  = 64'h1;
  localparam logic [63:0] ID_HEAP_OFF  = 64'h3;
  localparam logic [63:0] ID_PAY_LEN   = 64'h4;
  localparam logic [63:0] ID_CTRL      = 64'h6;
  localparam logic [63:0] ID_BASELINES = 64'h6005;
  localparam logic [63:0] ID_VIS_OFF   = 64'h600A;

  // Stream control value for end of stream
  localparam logic [63:0] CTRL_STOP = 64'd2;
  localparam logic [31:0] HEAP_BIAS = 32'd2;

  // Address width saturates at a full word
  localparam logic [7:0] ADDR_W_MAX = 8'd64;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_ITEMS   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_BAD      = 2'd0,
    ST_CONTROL  = 2'd1,
    ST_NO_PLACE = 2'd2,
    ST_PLACED   = 2'd3
  } status_t;

  // Decoded item pointer
  typedef struct packed {
    logic        heap_cnt;
    logic        heap_off;
    logic        pay_len;
    logic        ctrl;
    logic        baselines;
    logic        vis_off;
    logic [63:0] addr;
  } item_dec_t;

  // Packet state that feeds the summary
  typedef struct packed {
    logic        header_ok;
    logic        control_seen;
    logic [63:0] pkt_heap_offset;
    logic [63:0] pkt_payload_len;
    logic [63:0] pkt_vis_start;
    logic [63:0] vis_heap_offset;
    logic [31:0] baseline_count;
  } pkt_state_t;

endpackage

### hw/rtl/spead_header_item_parser_unit.sv
// SPEAD header item parser, top level. Depends on shp_pkg, shp_item_dec, shp_summary.
// Throughput: one packet word per cycle while a last word finds the result slot
// free; input and result registers decouple the two streams. The result
// register captures a last word's result. Synchronous active-high reset returns the
// parser to expecting a header and clears all held packet and stream state.
module spead_header_item_parser_unit (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] word
  input  logic         s_tlast,   // last word of packet
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // [31:0] heap_num, [95:32] vis_length,
                                  // [159:96] block_offset, [160] stream_done,
                                  // [167:161] zero
  output logic [1:0]   m_tuser    // [1:0] status
);

  // input register
  logic        in_v;
  logic [63:0] in_word;
  logic        in_last;
  logic        out_free;
  logic        proc_fire;

  // parser state
  shp_pkg::phase_t phase, phase_next;
  logic [7:0]  items_left, items_left_next;
  logic [6:0]  addr_width, addr_width_next;
  logic [7:0]  id_width, id_width_next;
  logic [31:0] heap_counter, heap_counter_next;
  logic        done_flag, done_flag_next;
  shp_pkg::pkt_state_t pst, pst_next;

  // header decode
  logic [7:0]  aw8;
  logic        hdr_ok;
  logic [7:0]  items_dec;

  shp_pkg::item_dec_t dec;
  shp_pkg::status_t   sum_status;
  logic [63:0]        sum_vlen;
  logic [63:0]        sum_boff;

  // result register
  logic [1:0]  res_status;
  logic [31:0] res_heap_num;
  logic [63:0] res_vlen;
  logic [63:0] res_boff;
  logic        res_done;

  // Handshake: a last word needs the result slot free
  assign out_free  = !m_tvalid || m_tready;
  assign proc_fire = in_v && (!in_last || out_free);
  assign s_tready  = !in_v || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word <= s_tdata;
      in_last <= s_tlast;
    end
  end

  shp_item_dec u_dec (
    .word       (in_word),
    .addr_width (addr_width),
    .id_width   (id_width),
    .dec        (dec)
  );

  // Header fields
  assign aw8       = {in_word[36:32], 3'b000};
  assign hdr_ok    = (in_word[63:56] == shp_pkg::MAGIC) && (in_word[55:48] == shp_pkg::VERSION);
  assign items_dec = items_left - 8'd1;

  // Next state for the word in the input register
  always_comb begin
    phase_next        = phase;
    items_left_next   = items_left;
    addr_width_next   = addr_width;
    id_width_next     = id_width;
    heap_counter_next = heap_counter;
    done_flag_next    = done_flag;
    pst_next          = pst;
    case (phase)
      shp_pkg::PH_HEADER: begin
        pst_next.control_seen    = 1'b0;
        pst_next.pkt_heap_offset = '0;
        pst_next.pkt_payload_len = '0;
        pst_next.pkt_vis_start   = '0;
        pst_next.header_ok       = hdr_ok;
        id_width_next            = {in_word[44:40], 3'b000} - 8'd1;
        addr_width_next          = (aw8 > shp_pkg::ADDR_W_MAX) ? 7'd64 : aw8[6:0];
        items_left_next          = hdr_ok ? in_word[7:0] : 8'd0;
        phase_next = (hdr_ok && (in_word[7:0] != 8'd0)) ? shp_pkg::PH_ITEMS
                                                       : shp_pkg::PH_PAYLOAD;
      end
      shp_pkg::PH_ITEMS: begin
        if (dec.heap_cnt) begin
          heap_counter_next = dec.addr[31:0] - shp_pkg::HEAP_BIAS;
        end
        if (dec.heap_off) begin
          pst_next.pkt_heap_offset = dec.addr;
        end
        if (dec.pay_len) begin
          pst_next.pkt_payload_len = dec.addr;
        end
        if (dec.ctrl) begin
          pst_next.control_seen = 1'b1;
          if (dec.addr == shp_pkg::CTRL_STOP) begin
            done_flag_next = 1'b1;
          end
        end
        if (dec.baselines) begin
          pst_next.baseline_count = {dec.addr[7:0], dec.addr[15:8],
                                     dec.addr[23:16], dec.addr[31:24]};
        end
        if (dec.vis_off) begin
          pst_next.vis_heap_offset = dec.addr;
          pst_next.pkt_vis_start   = dec.addr;
        end
        items_left_next = items_dec;
        if (items_dec == 8'd0) begin
          phase_next = shp_pkg::PH_PAYLOAD;
        end
      end
      shp_pkg::PH_PAYLOAD: begin
        phase_next = phase;
      end
      default: begin
        phase_next = shp_pkg::PH_HEADER;
      end
    endcase
    // End of packet rearms the header check
    if (in_last) begin
      phase_next      = shp_pkg::PH_HEADER;
      items_left_next = 8'd0;
    end
  end

  shp_summary u_sum (
    .st           (pst_next),
    .status       (sum_status),
    .vis_length   (sum_vlen),
    .block_offset (sum_boff)
  );

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= shp_pkg::PH_HEADER;
      items_left   <= '0;
      addr_width   <= '0;
      id_width     <= '0;
      heap_counter <= '0;
      done_flag    <= 1'b0;
      pst          <= '0;
    end else if (proc_fire) begin
      phase        <= phase_next;
      items_left   <= items_left_next;
      addr_width   <= addr_width_next;
      id_width     <= id_width_next;
      heap_counter <= heap_counter_next;
      done_flag    <= done_flag_next;
      pst          <= pst_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc_fire && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last) begin
      res_status   <= sum_status;
      res_heap_num <= heap_counter_next;
      res_vlen     <= sum_vlen;
      res_boff     <= sum_boff;
      res_done     <= done_flag_next;
    end
  end

  assign m_tuser = res_status;
  assign m_tdata = {7'd0, res_done, res_boff, res_vlen, res_heap_num};

  `include "spead_header_item_parser_unit_macros.svh"

  // Stream end flag never clears outside reset
  `SHP_ASSERT_NEXT(a_done_sticky, done_flag, done_flag)
  // Pending items only while walking the item list
  `SHP_ASSERT_NOW(a_items_phase, items_left != 8'd0, phase == shp_pkg::PH_ITEMS)
  // Placement fields stay zero unless data is placed
  `SHP_ASSERT_NOW(a_place_zero, m_tvalid && (m_tuser != shp_pkg::ST_PLACED),
                  m_tdata[159:32] == 128'd0)
  // A processed last word always yields a result
  `SHP_ASSERT_NEXT(a_last_result, proc_fire && in_last, m_tvalid)

endmodule

### hw/rtl/shp_item_dec.sv
// Item pointer decoder: splits a word into address and id and matches known ids.
// Depends on shp_pkg.
module shp_item_dec (
  input  logic [63:0]       word,
  input  logic [6:0]        addr_width,
  input  logic [7:0]        id_width,
  output shp_pkg::item_dec_t dec
);

  logic [63:0] addr_mask;
  logic [63:0] id_mask;
  logic [63:0] id_raw;
  logic [63:0] id;

  // Address takes the low bits, id the bits above
  assign addr_mask = addr_width[6] ? '1 : ((64'd1 << addr_width[5:0]) - 64'd1);
  assign id_raw    = addr_width[6] ? '0 : (word >> addr_width[5:0]);
  assign id_mask   = (|id_width[7:6]) ? '1 : ((64'd1 << id_width[5:0]) - 64'd1);
  assign id        = id_raw & id_mask;

  // Id match flags
  always_comb begin
    dec.addr      = word & addr_mask;
    dec.heap_cnt  = (id == shp_pkg::ID_HEAP_CNT);
    dec.heap_off  = (id == shp_pkg::ID_HEAP_OFF);
    dec.pay_len   = (id == shp_pkg::ID_PAY_LEN);
    dec.ctrl      = (id == shp_pkg::ID_CTRL);
    dec.baselines = (id == shp_pkg::ID_BASELINES);
    dec.vis_off   = (id == shp_pkg::ID_VIS_OFF);
  end

endmodule

### hw/rtl/shp_summary.sv
// Packet summary: status decision and placement arithmetic.
// Depends on shp_pkg.
module shp_summary (
  input  shp_pkg::pkt_state_t st,
  output shp_pkg::status_t    status,
  output logic [63:0]         vis_length,
  output logic [63:0]         block_offset
);

  logic placeable;

  // Visibility data placed when offset set and baseline count positive
  assign placeable = (st.vis_heap_offset != 64'd0) && (st.baseline_count != 32'd0) &&
                     !st.baseline_count[31];

  always_comb begin
    vis_length   = '0;
    block_offset = '0;
    if (!st.header_ok) begin
      status = shp_pkg::ST_BAD;
    end else if (st.control_seen) begin
      status = shp_pkg::ST_CONTROL;
    end else if (placeable) begin
      status       = shp_pkg::ST_PLACED;
      vis_length   = st.pkt_payload_len - st.pkt_vis_start;
      block_offset = st.pkt_heap_offset - st.vis_heap_offset + st.pkt_vis_start;
    end else begin
      status = shp_pkg::ST_NO_PLACE;
    end
  end

endmodule

### sim/spead_header_item_parser_unit_tb.sv
// Self-checking testbench for the SPEAD header item parser.
// Depends on shp_pkg and spead_header_item_parser_unit; a class keeps the
// packet summary predictor and the queue of summaries still due.
`timescale 1ns / 100ps

module spead_header_item_parser_unit_tb;

  localparam int WORD_TARGET    = 2000;
  localparam int QUIET_AFTER    = 1700;
  localparam int PRESSURE_AT    = 800;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int STD_AW         = 48;

  // Expected packet summary
  typedef struct packed {
    shp_pkg::status_t status;
    logic [31:0]      heap_num;
    logic [63:0]      vis_length;
    logic [63:0]      block_offset;
    logic             stream_done;
  } summary_t;

  // Packet parse predictor plus the summaries it still expects
  class summary_board;
    shp_pkg::phase_t phase;
    logic [7:0]  items_left;
    logic [6:0]  addr_width;
    logic [7:0]  id_width;
    logic        header_ok;
    logic        control_seen;
    logic [63:0] pkt_heap_offset;
    logic [63:0] pkt_payload_len;
    logic [63:0] pkt_vis_start;
    logic [31:0] heap_counter;
    logic        done_flag;
    logic [63:0] vis_heap_offset;
    logic [31:0] baseline_count;
    summary_t    summaries_due[$];
    int          errors;

    function new();
      phase           = shp_pkg::PH_HEADER;
      items_left      = '0;
      addr_width      = '0;
      id_width        = '0;
      header_ok       = 1'b0;
      control_seen    = 1'b0;
      pkt_heap_offset = '0;
      pkt_payload_len = '0;
      pkt_vis_start   = '0;
      heap_counter    = '0;
      done_flag       = 1'b0;
      vis_heap_offset = '0;
      baseline_count  = '0;
      errors          = 0;
    endfunction

    function logic [63:0] width_mask(logic [7:0] w);
      return (w >= 8'd64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function int pending();
      return summaries_due.size();
    endfunction

    // Split one item pointer into id and address and apply it
    function void decode_item(logic [63:0] w);
      logic [63:0] addr;
      logic [63:0] id;
      addr = w & width_mask({1'b0, addr_width});
      id   = (addr_width >= 7'd64) ? 64'd0 : (w >> addr_width);
      id   = id & width_mask(id_width);
      case (id)
        shp_pkg::ID_HEAP_CNT:  heap_counter = addr[31:0] - shp_pkg::HEAP_BIAS;
        shp_pkg::ID_HEAP_OFF:  pkt_heap_offset = addr;
        shp_pkg::ID_PAY_LEN:   pkt_payload_len = addr;
        shp_pkg::ID_CTRL: begin
          control_seen = 1'b1;
          if (addr == shp_pkg::CTRL_STOP) done_flag = 1'b1;
        end
        shp_pkg::ID_BASELINES: begin
          baseline_count = {addr[7:0], addr[15:8], addr[23:16], addr[31:24]};
        end
        shp_pkg::ID_VIS_OFF: begin
          vis_heap_offset = addr;
          pkt_vis_start   = addr;
        end
        default: ;
      endcase
    endfunction

    // Accepted input word: advance the parse, queue a summary on last
    function void note_word(logic [63:0] w, logic last);
      summary_t    exp;
      logic [7:0]  aw8;
      case (phase)
        shp_pkg::PH_HEADER: begin
          control_seen    = 1'b0;
          pkt_heap_offset = '0;
          pkt_payload_len = '0;
          pkt_vis_start   = '0;
          header_ok  = (w[63:56] == shp_pkg::MAGIC) && (w[55:48] == shp_pkg::VERSION);
          id_width   = {w[44:40], 3'b000} - 8'd1;
          aw8        = {w[36:32], 3'b000};
          addr_width = (aw8 > shp_pkg::ADDR_W_MAX) ? 7'd64 : aw8[6:0];
          items_left = header_ok ? w[7:0] : 8'd0;
          phase      = (items_left != 8'd0) ? shp_pkg::PH_ITEMS : shp_pkg::PH_PAYLOAD;
        end
        shp_pkg::PH_ITEMS: begin
          decode_item(w);
          items_left = items_left - 8'd1;
          if (items_left == 8'd0) phase = shp_pkg::PH_PAYLOAD;
        end
        default: ;
      endcase
      if (!last) return;
      exp = '0;
      if (!header_ok) begin
        exp.status = shp_pkg::ST_BAD;
      end else if (control_seen) begin
        exp.status = shp_pkg::ST_CONTROL;
      end else if (vis_heap_offset != 64'd0 && baseline_count != 32'd0 &&
                   !baseline_count[31]) begin
        exp.status       = shp_pkg::ST_PLACED;
        exp.vis_length   = pkt_payload_len - pkt_vis_start;
        exp.block_offset = pkt_heap_offset - vis_heap_offset + pkt_vis_start;
      end else begin
        exp.status = shp_pkg::ST_NO_PLACE;
      end
      exp.heap_num    = heap_counter;
      exp.stream_done = done_flag;
      summaries_due.push_back(exp);
      phase      = shp_pkg::PH_HEADER;
      items_left = '0;
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        $error("%s expected 0x%0h actual 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    // Accepted result item: compare with the oldest pending summary
    function void check_summary(logic [167:0] tdata, logic [1:0] tuser);
      summary_t exp;
      if (summaries_due.size() == 0) begin
        $error("summary item with none expected (tuser 0x%0h tdata 0x%0h)", tuser, tdata);
        errors++;
        return;
      end
      exp = summaries_due.pop_front();
      compare_field("status", 64'(exp.status), 64'(tuser));
      compare_field("heap_num", 64'(exp.heap_num), 64'(tdata[31:0]));
      compare_field("vis_length", exp.vis_length, tdata[95:32]);
      compare_field("block_offset", exp.block_offset, tdata[159:96]);
      compare_field("stream_done", 64'(exp.stream_done), 64'(tdata[160]));
      compare_field("pad", 64'd0, 64'(tdata[167:161]));
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;   // [63:0] word
  logic         s_tlast;   // last word of packet
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;   // [31:0] heap_num, [95:32] vis_length,
                           // [159:96] block_offset, [160] stream_done, [167:161] zero
  logic [1:0]   m_tuser;   // [1:0] status

  summary_board board = new();

  logic [63:0] pkt_words[$];
  int          words_sent;
  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_hold_req;
  bit          pressure_done;
  int          drain_cycles;

  spead_header_item_parser_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Both handshakes observed at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_word(s_tdata, s_tlast);
      if (m_tvalid && m_tready) board.check_summary(m_tdata, m_tuser);
    end
  end

  // Result side: random stalls, one long hold on request
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      if (rx_hold_req) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        @(negedge clk) m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] header_word(logic [7:0] magic, logic [7:0] ver,
                                              logic [7:0] idb, logic [7:0] adb,
                                              logic [7:0] n);
    return {magic, ver, idb, adb, 24'h0, n};
  endfunction

  // Item pointer: id above an aw-bit address
  function automatic logic [63:0] item_ptr(int aw, logic [63:0] id, logic [63:0] addr);
    if (aw >= 64) return addr;
    return (id << aw) | (addr & ((64'd1 << aw) - 64'd1));
  endfunction

  // Offer one item, with an optional idle burst before it
  task automatic send_word(logic [63:0] w, logic last);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_pkt();
    foreach (pkt_words[i]) send_word(pkt_words[i], i == pkt_words.size() - 1);
  endtask

  // Stop offering and wait for every due summary
  task automatic wait_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed packets with random items; the rest is noise
  task automatic build_random_packet();
    int          kind;
    int          n;
    int          aw;
    int          npay;
    int          cut;
    logic [7:0]  idb;
    logic [7:0]  adb;
    logic [63:0] id;
    logic [63:0] addr;
    pkt_words.delete();
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      idb = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd2;
      adb = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd6;
      n   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      pkt_words.push_back({shp_pkg::MAGIC, shp_pkg::VERSION, idb, adb,
                           24'($urandom), 8'(n)});
      aw = (int'(adb) * 8) & 255;
      if (aw > 64) aw = 64;
      for (int i = 0; i < n; i++) begin
        addr = rand64();
        case ($urandom_range(0, 7))
          0: id = shp_pkg::ID_HEAP_CNT;
          1: id = shp_pkg::ID_HEAP_OFF;
          2: id = shp_pkg::ID_PAY_LEN;
          3: begin
            id   = shp_pkg::ID_CTRL;
            addr = ($urandom_range(0, 49) == 0) ? shp_pkg::CTRL_STOP
                                                : 64'($urandom_range(0, 5));
          end
          4: id = shp_pkg::ID_BASELINES;
          5: begin
            id = shp_pkg::ID_VIS_OFF;
            if ($urandom_range(0, 4) == 0) addr = '0;
          end
          6: id = 64'($urandom_range(0, 16'hFFFF));
          default: id = 64'hX;
        endcase
        if ($isunknown(id)) begin
          pkt_words.push_back(rand64());
        end else begin
          // random flag bit above a 15-bit id
          id = id | (64'($urandom_range(0, 1)) << 15);
          pkt_words.push_back(item_ptr(aw, id, addr));
        end
      end
      npay = $urandom_range(0, 3);
      repeat (npay) pkt_words.push_back(rand64());
      // packet cut short, possibly inside the item list
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, pkt_words.size());
        while (pkt_words.size() > cut) void'(pkt_words.pop_back());
      end
    end else begin
      if (kind == 8) pkt_words.push_back(rand64());
      else pkt_words.push_back({shp_pkg::MAGIC, 8'($urandom_range(0, 255)), 48'(rand64())});
      repeat ($urandom_range(0, 4)) pkt_words.push_back(rand64());
    end
  endtask

  // Stimulus
  initial begin
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    words_sent    = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold_req   = 1'b0;
    pressure_done = 1'b0;
    wait (!rst);

    // bad headers: all zeros, all ones, wrong version with items to ignore
    send_word(64'd0, 1'b1);
    send_word('1, 1'b1);
    send_word(header_word(shp_pkg::MAGIC, 8'h05, 8'd2, 8'd6, 8'd2), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_HEAP_CNT, 64'd9), 1'b0);
    send_word(rand64(), 1'b1);
    // header marked last
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd2, 8'd6, 8'd0), 1'b1);
    // full packet: every id but stream control, heap counter wrap, unknown id, payload after list
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd2, 8'd6, 8'd7), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_HEAP_CNT, 64'd0), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_HEAP_OFF, 64'h1000), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_PAY_LEN, 64'h2000), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_BASELINES, 64'h0100_0000), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_VIS_OFF | 64'h8000, 64'h800), 1'b0);
    send_word(item_ptr(STD_AW, 64'h7FFF, '1), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_HEAP_CNT, 64'h1_0000_0005), 1'b0);
    send_word(rand64(), 1'b0);
    send_word(rand64(), 1'b1);
    // 64-bit address, packet ends inside the item list
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd2, 8'd8, 8'd2), 1'b0);
    send_word('1, 1'b1);
    // address width past 64 saturates, id width wraps to all ones
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd0, 8'd9, 8'd1), 1'b0);
    send_word(64'h0000_6005_0000_0001, 1'b1);
    // wide id with a negative baseline count
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd9, 8'd2, 8'd1), 1'b0);
    send_word(item_ptr(16, shp_pkg::ID_BASELINES, 64'h0080), 1'b1);
    // stream control, then end of stream
    send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd2, 8'd6, 8'd2), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_CTRL, 64'd3), 1'b0);
    send_word(item_ptr(STD_AW, shp_pkg::ID_CTRL, shp_pkg::CTRL_STOP), 1'b1);
    wait_drained();

    // random packets
    while (words_sent < WORD_TARGET) begin
      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        // long result stall while short packets keep coming
        rx_hold_req = 1'b1;
        repeat (30) begin
          send_word(header_word(shp_pkg::MAGIC, shp_pkg::VERSION, 8'd2, 8'd6, 8'd0), 1'b1);
        end
        wait_drained();
        pressure_done = 1'b1;
      end
      if (words_sent >= QUIET_AFTER) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      build_random_packet();
      send_pkt();
    end
    @(negedge clk) s_tvalid <= 1'b0;

    // drain and report
    drain_cycles = 0;
    while (board.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d summaries never arrived", board.pending());
      board.errors++;
    end
    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
